/* rtl/core/assert_macros.svh */
// Assertion macros shared by the parser RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define NTRP_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ntrp assertion failed");

// Clocked condition that must never hold.
`define NTRP_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ntrp forbidden condition seen");

`endif

/* rtl/core/ntrp_pkg.sv */
// Types and constants shared by the response-frame parser modules.
`timescale 1ns / 1ps
package ntrp_pkg;

  // frame positions
  localparam logic [8:0] POS_LEN  = 9'd3;
  localparam logic [8:0] POS_LCS  = 9'd4;
  localparam logic [8:0] POS_TFI  = 9'd5;
  localparam logic [8:0] POS_DATA = 9'd7;
  localparam logic [8:0] POS_MAX  = 9'd511;

  // LEN covers TFI and the command echo
  localparam logic [7:0] LEN_OVERHEAD = 8'd2;

  // data byte indexes
  localparam int unsigned CAP_IDX_W = 4;
  localparam logic [CAP_IDX_W-1:0] DI_COUNT   = 4'd0;
  localparam logic [CAP_IDX_W-1:0] DI_ATQA_LO = 4'd2;
  localparam logic [CAP_IDX_W-1:0] DI_ATQA_HI = 4'd3;
  localparam logic [CAP_IDX_W-1:0] DI_SAK     = 4'd4;
  localparam logic [CAP_IDX_W-1:0] DI_UID_LEN = 4'd5;
  localparam logic [CAP_IDX_W-1:0] DI_UID0    = 4'd6;

  localparam int unsigned UID_BYTES = 7;
  localparam logic [8:0] CAP_SPAN = 9'(DI_UID0) + 9'(UID_BYTES);
  localparam logic [7:0] MIN_DATA = 8'd7;

  // result status codes
  localparam logic [2:0] ST_CARD        = 3'd0;
  localparam logic [2:0] ST_LCS_BAD     = 3'd1;
  localparam logic [2:0] ST_BAD_TFI     = 3'd2;
  localparam logic [2:0] ST_SHORT_LEN   = 3'd3;
  localparam logic [2:0] ST_FEW_DATA    = 3'd4;
  localparam logic [2:0] ST_NO_TARGET   = 3'd5;
  localparam logic [2:0] ST_UID_OVERRUN = 3'd6;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_CAPTURE,
    OP_FAIL,
    OP_FINAL
  } ntrp_op_kind_e;

  // CAPTURE: idx = data index, value = byte
  // FAIL:    value = status code
  // FINAL:   value = data length
  typedef struct packed {
    ntrp_op_kind_e          kind;
    logic [CAP_IDX_W-1:0]   idx;
    logic [7:0]             value;
  } ntrp_op_t;

endpackage

/* rtl/core/ntrp_if.sv */
// Channel interfaces: received bytes, parse results and configuration writes.
`timescale 1ns / 1ps
interface ntrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_start;
  modport source (output valid, rx_byte, frame_start, input ready);
  modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

interface ntrp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  target_count;
  logic [15:0] atqa;
  logic [7:0]  sak;
  logic [2:0]  uid_length;
  logic [55:0] uid;
  logic [7:0]  data_length;
  modport source (output valid, status, target_count, atqa, sak, uid_length, uid,
                  data_length, input ready);
  modport sink (input valid, status, target_count, atqa, sak, uid_length, uid,
                data_length, output ready);
endinterface

interface ntrp_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

/* rtl/core/ntrp_front.sv */
// Front end: bit reversal, frame position tracking, header checks, op generation.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ntrp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  ntrp_in_if.sink            rx_i,
  ntrp_cfg_if.sink           cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output ntrp_pkg::ntrp_op_t op_o
);
  import ntrp_pkg::*;

  logic [8:0] pos_q, pos_d;
  logic [7:0] flen_q, flen_d;
  logic       active_q, active_d;
  logic [7:0] frame_id_q;
  logic [7:0] b;
  logic       accept;
  logic [8:0] d_idx;
  logic [7:0] dlen;
  logic [7:0] lcs_sum;

  assign rx_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = rx_i.valid && !full_i;
  assign d_idx       = pos_q - POS_DATA;
  assign dlen        = flen_q - LEN_OVERHEAD;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      b[i] = rx_i.rx_byte[7-i];
    end
  end

  assign lcs_sum = flen_q + b;

  always_comb begin
    pos_d    = pos_q;
    flen_d   = flen_q;
    active_d = active_q;
    push_o   = 1'b0;
    op_o     = '{kind: OP_CLEAR, idx: '0, value: '0};
    if (accept) begin
      if (rx_i.frame_start) begin
        pos_d    = 9'd1;
        flen_d   = '0;
        active_d = 1'b1;
        push_o   = 1'b1;
      end else if (active_q) begin
        if (pos_q == POS_LEN) begin
          flen_d = b;
        end else if (pos_q == POS_LCS) begin
          if (lcs_sum != 8'h00) begin
            push_o   = 1'b1;
            op_o     = '{kind: OP_FAIL, idx: '0, value: 8'(ST_LCS_BAD)};
            active_d = 1'b0;
          end
        end else if (pos_q == POS_TFI) begin
          if (b != frame_id_q) begin
            push_o   = 1'b1;
            op_o     = '{kind: OP_FAIL, idx: '0, value: 8'(ST_BAD_TFI)};
            active_d = 1'b0;
          end else if (flen_q < LEN_OVERHEAD) begin
            push_o   = 1'b1;
            op_o     = '{kind: OP_FAIL, idx: '0, value: 8'(ST_SHORT_LEN)};
            active_d = 1'b0;
          end
        end else if (pos_q >= POS_DATA) begin
          if (d_idx < {1'b0, dlen}) begin
            if (d_idx < CAP_SPAN) begin
              push_o = 1'b1;
              op_o   = '{kind: OP_CAPTURE, idx: d_idx[CAP_IDX_W-1:0], value: b};
            end
          end else if (d_idx > {1'b0, dlen}) begin
            push_o   = 1'b1;
            op_o     = '{kind: OP_FINAL, idx: '0, value: dlen};
            active_d = 1'b0;
          end
        end
        if (active_d && pos_q != POS_MAX) begin
          pos_d = pos_q + 9'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      flen_q     <= '0;
      active_q   <= 1'b0;
      frame_id_q <= 8'hD5;
    end else begin
      pos_q    <= pos_d;
      flen_q   <= flen_d;
      active_q <= active_d;
      if (cfg_i.valid) begin
        frame_id_q <= cfg_i.data;
      end
    end
  end

  `NTRP_ASSERT(a_end_stops, clk_i, rst_ni,
    push_o && (op_o.kind == OP_FAIL || op_o.kind == OP_FINAL) |=> !active_q)

endmodule

/* rtl/core/ntrp_queue.sv */
// Two-entry op queue decoupling the front end from the capture back end.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ntrp_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ntrp_pkg::ntrp_op_t op_i,
  output logic               full_o,
  output logic               valid_o,
  output ntrp_pkg::ntrp_op_t op_o,
  input  logic               pop_i
);
  import ntrp_pkg::*;

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ntrp_op_t         mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign op_o    = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  `NTRP_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o)
  `NTRP_ASSERT(a_cnt_up, clk_i, rst_ni,
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)

endmodule

/* rtl/core/ntrp_back.sv */
// Back end: holds the captured listing fields and builds the result transaction.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ntrp_back #(
  parameter int unsigned MAX_UID_BYTES = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  ntrp_pkg::ntrp_op_t op_i,
  output logic               pop_o,
  ntrp_out_if.source         res_o
);
  import ntrp_pkg::*;

  localparam int unsigned ULW = $clog2(MAX_UID_BYTES + 1);

  logic [7:0]  count_q;
  logic [15:0] atqa_q;
  logic [7:0]  sak_q;
  logic [7:0]  rawlen_q;
  logic [55:0] uid_q;

  logic        out_valid_q;
  logic [2:0]  status_q;
  logic [7:0]  tcount_q;
  logic [15:0] ratqa_q;
  logic [7:0]  rsak_q;
  logic [2:0]  ulen_q;
  logic [55:0] ruid_q;
  logic [7:0]  dlen_q;

  logic        is_res, slot_free, take;
  logic [ULW-1:0] ul;
  logic [8:0]  need;
  logic [2:0]  shown;
  logic [55:0] uid_masked;
  logic [2:0]  fin_status;

  assign is_res    = (op_i.kind == OP_FAIL) || (op_i.kind == OP_FINAL);
  assign slot_free = !out_valid_q || res_o.ready;
  assign pop_o     = valid_i && (!is_res || slot_free);
  assign take      = pop_o;

  assign ul    = (rawlen_q > 8'(MAX_UID_BYTES)) ? ULW'(MAX_UID_BYTES) : ULW'(rawlen_q);
  assign need  = 9'(DI_UID0) + 9'(ul);
  assign shown = (ul > ULW'(UID_BYTES)) ? 3'(UID_BYTES) : 3'(ul);

  always_comb begin
    for (int i = 0; i < UID_BYTES; i++) begin
      uid_masked[8*i +: 8] = (3'(i) < shown) ? uid_q[8*i +: 8] : 8'h00;
    end
  end

  always_comb begin
    if (op_i.value < MIN_DATA) begin
      fin_status = ST_FEW_DATA;
    end else if (count_q == 8'h00) begin
      fin_status = ST_NO_TARGET;
    end else if ({1'b0, op_i.value} < need) begin
      fin_status = ST_UID_OVERRUN;
    end else begin
      fin_status = ST_CARD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      atqa_q   <= '0;
      sak_q    <= '0;
      rawlen_q <= '0;
      uid_q    <= '0;
    end else if (take) begin
      case (op_i.kind)
        OP_CLEAR: begin
          count_q  <= '0;
          atqa_q   <= '0;
          sak_q    <= '0;
          rawlen_q <= '0;
          uid_q    <= '0;
        end
        OP_CAPTURE: begin
          if (op_i.idx == DI_COUNT) count_q <= op_i.value;
          if (op_i.idx == DI_ATQA_LO) atqa_q[7:0] <= op_i.value;
          if (op_i.idx == DI_ATQA_HI) atqa_q[15:8] <= op_i.value;
          if (op_i.idx == DI_SAK) sak_q <= op_i.value;
          if (op_i.idx == DI_UID_LEN) rawlen_q <= op_i.value;
          for (int i = 0; i < UID_BYTES; i++) begin
            if (op_i.idx == DI_UID0 + CAP_IDX_W'(i)) uid_q[8*i +: 8] <= op_i.value;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && is_res) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && is_res) begin
      if (op_i.kind == OP_FAIL || fin_status != ST_CARD) begin
        status_q <= (op_i.kind == OP_FAIL) ? op_i.value[2:0] : fin_status;
        tcount_q <= '0;
        ratqa_q  <= '0;
        rsak_q   <= '0;
        ulen_q   <= '0;
        ruid_q   <= '0;
        dlen_q   <= (op_i.kind == OP_FAIL) ? 8'h00 : op_i.value;
      end else begin
        status_q <= ST_CARD;
        tcount_q <= count_q;
        ratqa_q  <= atqa_q;
        rsak_q   <= sak_q;
        ulen_q   <= shown;
        ruid_q   <= uid_masked;
        dlen_q   <= op_i.value;
      end
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.status       = status_q;
  assign res_o.target_count = tcount_q;
  assign res_o.atqa         = ratqa_q;
  assign res_o.sak          = rsak_q;
  assign res_o.uid_length   = ulen_q;
  assign res_o.uid          = ruid_q;
  assign res_o.data_length  = dlen_q;

  `NTRP_ASSERT(a_clear_zeroes, clk_i, rst_ni,
    take && op_i.kind == OP_CLEAR |=> count_q == 8'h00 && uid_q == '0)
  `NTRP_ASSERT_NEVER(a_result_no_slot, clk_i, rst_ni, take && is_res && !slot_free)

endmodule

/* rtl/core/nfc_target_response_parser.sv */
// Top level of the reader response-frame parser.
`timescale 1ns / 1ps
// Parses one received SPI byte per transaction on rx_chan_i and sustains one byte
// per clock cycle while the queue is not full. The front end reverses bit order,
// tracks the frame position and checks LEN/LCS and the frame identifier in the
// cycle a byte is taken; it hands capture and end-of-frame ops through a two-entry
// queue to the back end, which holds the listing fields and registers the result.
// A result transaction becomes valid on res_chan_o once the back end takes the op
// that ends or fails the frame from the queue, and waits there while new bytes
// keep flowing until the queue fills. The frame identifier register (reset 0xD5)
// is written through cfg_chan_i, which is always ready.
module nfc_target_response_parser #(
  parameter int unsigned MAX_UID_BYTES = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ntrp_in_if.sink     rx_chan_i,
  ntrp_cfg_if.sink    cfg_chan_i,
  ntrp_out_if.source  res_chan_o
);
  import ntrp_pkg::*;

  logic     push, full, q_valid, pop;
  ntrp_op_t push_op, q_op;

  ntrp_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_chan_i),
    .cfg_i  (cfg_chan_i),
    .full_i (full),
    .push_o (push),
    .op_o   (push_op)
  );

  ntrp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .full_o  (full),
    .valid_o (q_valid),
    .op_o    (q_op),
    .pop_i   (pop)
  );

  ntrp_back #(
    .MAX_UID_BYTES (MAX_UID_BYTES)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .op_i    (q_op),
    .pop_o   (pop),
    .res_o   (res_chan_o)
  );

endmodule

/* sim/ntrp_result_checker.sv */
// Scoreboard for the response-frame parser: predicts every parse result and checks it.
`timescale 1ns / 1ps
module ntrp_result_checker #(
  parameter int unsigned MAX_UID = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        byte_valid_i,
  input  logic        byte_ready_i,
  input  logic [7:0]  rx_byte_i,
  input  logic        frame_start_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [2:0]  status_i,
  input  logic [7:0]  target_count_i,
  input  logic [15:0] atqa_i,
  input  logic [7:0]  sak_i,
  input  logic [2:0]  uid_length_i,
  input  logic [55:0] uid_i,
  input  logic [7:0]  data_length_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  import ntrp_pkg::*;

  localparam logic [7:0] FRAME_ID_RESET = 8'hD5;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  target_count;
    logic [15:0] atqa;
    logic [7:0]  sak;
    logic [2:0]  uid_length;
    logic [55:0] uid;
    logic [7:0]  data_length;
  } frame_report_t;

  frame_report_t expected_reports[$];
  int unsigned   mismatches;

  logic [7:0]  frame_id;
  logic [8:0]  pos;
  logic [7:0]  len_byte;
  logic        in_frame;
  logic [7:0]  targets;
  logic [15:0] atqa_acc;
  logic [7:0]  sak_acc;
  logic [7:0]  uid_len_raw;
  logic [55:0] uid_acc;

  function automatic logic [7:0] reverse_bits(input logic [7:0] v);
    logic [7:0] m;
    for (int i = 0; i < 8; i++) m[i] = v[7-i];
    return m;
  endfunction

  function automatic void clear_listing();
    pos         = '0;
    len_byte    = '0;
    targets     = '0;
    atqa_acc    = '0;
    sak_acc     = '0;
    uid_len_raw = '0;
    uid_acc     = '0;
  endfunction

  function automatic frame_report_t failure(input logic [2:0] code, input logic [7:0] dlen);
    frame_report_t r;
    r = '0;
    r.status = code;
    r.data_length = dlen;
    return r;
  endfunction

  function automatic frame_report_t close_frame();
    frame_report_t r;
    int dlen;
    int ul;
    int shown;
    dlen = int'(len_byte) - 2;
    if (dlen < int'(MIN_DATA)) return failure(ST_FEW_DATA, dlen[7:0]);
    if (targets == 8'd0) return failure(ST_NO_TARGET, dlen[7:0]);
    ul = (int'(uid_len_raw) > int'(MAX_UID)) ? int'(MAX_UID) : int'(uid_len_raw);
    if (dlen < int'(DI_UID0) + ul) return failure(ST_UID_OVERRUN, dlen[7:0]);
    shown = (ul > int'(UID_BYTES)) ? int'(UID_BYTES) : ul;
    r = '0;
    r.status       = ST_CARD;
    r.target_count = targets;
    r.atqa         = atqa_acc;
    r.sak          = sak_acc;
    r.uid_length   = shown[2:0];
    for (int i = 0; i < shown; i++) r.uid[8*i +: 8] = uid_acc[8*i +: 8];
    r.data_length  = dlen[7:0];
    return r;
  endfunction

  // returns 1 when this byte ends or fails the frame
  function automatic bit advance_frame(input logic [7:0] wire_byte, input logic first,
                                       output frame_report_t r);
    logic [7:0] b;
    logic [7:0] sum;
    int d;
    int dlen;
    bit done;
    b = reverse_bits(wire_byte);
    done = 1'b0;
    r = '0;
    if (first) begin
      clear_listing();
      in_frame = 1'b1;
    end
    if (!in_frame) return 1'b0;
    if (pos == POS_LEN) begin
      len_byte = b;
    end else if (pos == POS_LCS) begin
      sum = len_byte + b;
      if (sum != 8'd0) begin
        r = failure(ST_LCS_BAD, 8'd0);
        done = 1'b1;
      end
    end else if (pos == POS_TFI) begin
      if (b != frame_id) begin
        r = failure(ST_BAD_TFI, 8'd0);
        done = 1'b1;
      end else if (len_byte < LEN_OVERHEAD) begin
        r = failure(ST_SHORT_LEN, 8'd0);
        done = 1'b1;
      end
    end else if (pos >= POS_DATA) begin
      d = int'(pos) - int'(POS_DATA);
      dlen = int'(len_byte) - int'(LEN_OVERHEAD);
      if (d < dlen) begin
        if (d == int'(DI_COUNT)) targets = b;
        else if (d == int'(DI_ATQA_LO)) atqa_acc[7:0] = b;
        else if (d == int'(DI_ATQA_HI)) atqa_acc[15:8] = b;
        else if (d == int'(DI_SAK)) sak_acc = b;
        else if (d == int'(DI_UID_LEN)) uid_len_raw = b;
        else if (d >= int'(DI_UID0) && d < int'(CAP_SPAN)) uid_acc[8*(d-int'(DI_UID0)) +: 8] = b;
      end else if (d > dlen) begin
        r = close_frame();
        done = 1'b1;
      end
    end
    if (done) in_frame = 1'b0;
    if (in_frame && pos != POS_MAX) pos = pos + 9'd1;
    return done;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_report_t want;
    frame_report_t pred;
    if (!rst_ni) begin
      expected_reports.delete();
      mismatches = 0;
      frame_id = FRAME_ID_RESET;
      in_frame = 1'b0;
      clear_listing();
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        if (expected_reports.size() == 0) begin
          $error("result transaction with none expected, status %0d", status_i);
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", 64'(want.status), 64'(status_i));
          check_field("target_count", 64'(want.target_count), 64'(target_count_i));
          check_field("atqa", 64'(want.atqa), 64'(atqa_i));
          check_field("sak", 64'(want.sak), 64'(sak_i));
          check_field("uid_length", 64'(want.uid_length), 64'(uid_length_i));
          check_field("uid", 64'(want.uid), 64'(uid_i));
          check_field("data_length", 64'(want.data_length), 64'(data_length_i));
        end
      end
      if (byte_valid_i && byte_ready_i) begin
        if (advance_frame(rx_byte_i, frame_start_i, pred)) expected_reports.push_back(pred);
      end
      if (cfg_valid_i && cfg_ready_i) frame_id = cfg_data_i;
      fail_count_o <= mismatches;
      pending_o <= expected_reports.size();
    end
  end

endmodule

/* sim/tb_nfc_target_response_parser.sv */
// Testbench top for the response-frame parser: frame stimulus, back-pressure, verdict.
`timescale 1ns / 1ps
module tb_nfc_target_response_parser;

  localparam int unsigned MAX_UID        = 7;
  localparam logic [7:0]  FRAME_ID_RESET = 8'hD5;
  localparam logic [7:0]  PREAMBLE       = 8'h00;
  localparam logic [7:0]  START_CODE_HI  = 8'hFF;
  localparam logic [7:0]  CMD_ECHO       = 8'h4B;
  localparam logic [7:0]  POSTAMBLE      = 8'h00;
  localparam int unsigned PHASE_BYTES    = 440;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned SETTLE_CYCLES  = 8;

  typedef logic [7:0] octet_q_t[$];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned mismatch_count;
  int unsigned open_reports;
  int unsigned send_calm;
  int unsigned frames_sent;
  logic [7:0]  frame_id_now;

  always #5 clk = ~clk;

  ntrp_in_if  rx_chan ();
  ntrp_cfg_if cfg_chan ();
  ntrp_out_if res_chan ();

  nfc_target_response_parser #(
    .MAX_UID_BYTES(MAX_UID)
  ) dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .rx_chan_i (rx_chan),
    .cfg_chan_i(cfg_chan),
    .res_chan_o(res_chan)
  );

  ntrp_result_checker #(
    .MAX_UID(MAX_UID)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .byte_valid_i  (rx_chan.valid),
    .byte_ready_i  (rx_chan.ready),
    .rx_byte_i     (rx_chan.rx_byte),
    .frame_start_i (rx_chan.frame_start),
    .cfg_valid_i   (cfg_chan.valid),
    .cfg_ready_i   (cfg_chan.ready),
    .cfg_data_i    (cfg_chan.data),
    .res_valid_i   (res_chan.valid),
    .res_ready_i   (res_chan.ready),
    .status_i      (res_chan.status),
    .target_count_i(res_chan.target_count),
    .atqa_i        (res_chan.atqa),
    .sak_i         (res_chan.sak),
    .uid_length_i  (res_chan.uid_length),
    .uid_i         (res_chan.uid),
    .data_length_i (res_chan.data_length),
    .fail_count_o  (mismatch_count),
    .pending_o     (open_reports)
  );

  function automatic logic [7:0] spi_order(input logic [7:0] v);
    logic [7:0] m;
    for (int i = 0; i < 8; i++) m[i] = v[7-i];
    return m;
  endfunction

  // mostly short gaps, rare long ones, and calm stretches with none
  function automatic int unsigned next_gap(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) calm = $urandom_range(20, 80);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  function automatic octet_q_t build_frame(input logic [7:0] len, input logic [7:0] lcs,
                                           input logic [7:0] tfi, input octet_q_t body);
    octet_q_t f;
    f.push_back(PREAMBLE);
    f.push_back(PREAMBLE);
    f.push_back(START_CODE_HI);
    f.push_back(len);
    f.push_back(lcs);
    f.push_back(tfi);
    f.push_back(CMD_ECHO);
    foreach (body[i]) f.push_back(body[i]);
    f.push_back(8'($urandom_range(0, 255)));
    f.push_back(POSTAMBLE);
    return f;
  endfunction

  function automatic octet_q_t random_frame(input logic [7:0] tfi_now, input int unsigned big_len);
    octet_q_t body;
    octet_q_t f;
    int unsigned dlen;
    int unsigned ul;
    int unsigned r;
    logic [7:0] len;
    logic [7:0] lcs;
    logic [7:0] tfi;
    r = $urandom_range(0, 99);
    ul = (r < 80) ? $urandom_range(0, 7) : $urandom_range(8, 255);
    dlen = 6 + ((ul > 7) ? 7 : ul);
    r = $urandom_range(0, 99);
    if (big_len != 0) dlen = big_len;
    else if (r < 70) dlen += $urandom_range(0, 3);
    else if (r < 85) dlen = $urandom_range(0, dlen - 1);
    else dlen = $urandom_range(0, 24);
    for (int unsigned i = 0; i < dlen; i++) body.push_back(8'($urandom_range(0, 255)));
    if (dlen > 0) body[0] = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
    if (dlen > 5) body[5] = ul[7:0];
    len = 8'(dlen + 2);
    if ($urandom_range(0, 99) < 5) len = 8'($urandom_range(0, 1));
    lcs = 8'd0 - len;
    tfi = tfi_now;
    r = $urandom_range(0, 99);
    if (r < 7) lcs = lcs ^ 8'($urandom_range(1, 255));
    else if (r < 14) tfi = tfi ^ 8'($urandom_range(1, 255));
    f = build_frame(len, lcs, tfi, body);
    if ($urandom_range(0, 4) == 0) begin
      for (int i = 0; i < 3; i++) f[i] = 8'($urandom_range(0, 255));
      f[f.size() - 1] = 8'($urandom_range(0, 255));
    end
    return f;
  endfunction

  task automatic push_byte(input logic [7:0] value, input logic first);
    int unsigned gap;
    gap = next_gap(send_calm);
    if (gap != 0) begin
      rx_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_chan.valid <= 1'b1;
    rx_chan.rx_byte <= spi_order(value);
    rx_chan.frame_start <= first;
    do @(posedge clk); while (!rx_chan.ready);
  endtask

  task automatic send_frame(input octet_q_t f, input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_byte(f[i], i == 0);
    frames_sent++;
  endtask

  task automatic drain();
    rx_chan.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (open_reports != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_frame_id(input logic [7:0] id);
    cfg_chan.valid <= 1'b1;
    cfg_chan.data <= id;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    frame_id_now = id;
  endtask

  task automatic random_phase(input int unsigned quota);
    octet_q_t f;
    int unsigned sent;
    int unsigned cut;
    int unsigned k;
    int unsigned r;
    int unsigned big_len;
    sent = 0;
    while (sent < quota) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end else if (r < 11) begin
        k = $urandom_range(1, 12);
        push_byte(8'($urandom_range(0, 255)), 1'b1);
        repeat (k) push_byte(8'($urandom_range(0, 255)), 1'b0);
        sent += k + 1;
      end
      big_len = 0;
      if (frames_sent == 40) big_len = 253;
      else if ($urandom_range(0, 149) == 0) big_len = $urandom_range(100, 252);
      f = random_frame(frame_id_now, big_len);
      cut = f.size();
      if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, f.size() - 1);
      send_frame(f, cut);
      sent += cut;
    end
  endtask

  initial begin
    octet_q_t body;
    rx_chan.valid = 1'b0;
    rx_chan.rx_byte = 8'd0;
    rx_chan.frame_start = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.data = 8'd0;
    send_calm = 0;
    frames_sent = 0;
    frame_id_now = FRAME_ID_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // bytes outside a frame, then early failures, restart, empty listing, full card
    push_byte(8'hA5, 1'b0);
    push_byte(8'h5A, 1'b0);
    send_frame(build_frame(8'h05, 8'h00, FRAME_ID_RESET, body), 9);
    send_frame(build_frame(8'h04, 8'hFC, 8'hD4, body), 9);
    send_frame(build_frame(8'h01, 8'hFF, FRAME_ID_RESET, body), 9);
    send_frame(build_frame(8'h02, 8'hFE, FRAME_ID_RESET, body), 3);
    send_frame(build_frame(8'h02, 8'hFE, FRAME_ID_RESET, body), 9);
    body = '{8'h01, 8'h01, 8'h44, 8'h00, 8'h08, 8'hFF,
             8'h04, 8'hA1, 8'hB2, 8'hC3, 8'hD4, 8'hE5, 8'hF6};
    send_frame(build_frame(8'h0F, 8'hF1, FRAME_ID_RESET, body), 22);
    drain();

    write_frame_id(8'h00);
    random_phase(PHASE_BYTES);
    drain();
    write_frame_id(8'hFF);
    random_phase(PHASE_BYTES);
    drain();
    write_frame_id(8'($urandom_range(1, 254)));
    random_phase(PHASE_BYTES);
    drain();
    write_frame_id(FRAME_ID_RESET);
    random_phase(PHASE_BYTES);
    drain();

    if (mismatch_count == 0 && open_reports == 0) begin
      $display("tb_nfc_target_response_parser: done, clean");
    end else begin
      $display("tb_nfc_target_response_parser: done, errors");
    end
    $finish;
  end

  // result sink: random stalls plus two long hold-offs while bytes keep coming
  initial begin
    int unsigned gap;
    int unsigned calm;
    int unsigned seen;
    int unsigned holds;
    res_chan.ready = 1'b0;
    calm = 0;
    seen = 0;
    holds = 0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (holds < 2 && seen >= 30 + 40 * holds) begin
        res_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds++;
      end
      gap = next_gap(calm);
      if (gap != 0) begin
        res_chan.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_chan.ready <= 1'b1;
      @(posedge clk);
      if (res_chan.valid) seen++;
    end
  end

  initial begin
    #8000000;
    $display("tb_nfc_target_response_parser: done, errors");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/ntrp_pkg.sv
rtl/core/ntrp_if.sv
rtl/core/ntrp_front.sv
rtl/core/ntrp_queue.sv
rtl/core/ntrp_back.sv
rtl/core/nfc_target_response_parser.sv
sim/ntrp_result_checker.sv
sim/tb_nfc_target_response_parser.sv
